// ===== rtl/mbe_pkg.sv =====
`timescale 1ns / 1ps

package mbe_pkg;

    // Default geometry of the block
    localparam int COORD_WIDTH_DEFAULT = 32;
    localparam int FRAC_BITS_DEFAULT   = 28;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Multiplier limb width and width of the saturated squares (limit 2^63-1)
    localparam int LIMB_W = 32;
    localparam int SQ_W   = 63;

    // Configuration registers
    localparam int             CUTOFF_W       = 5;
    localparam logic [4:0]     CUTOFF_RESET   = 5'd4;
    localparam int             MAX_ITER_RESET = 256;

    typedef enum logic [0:0] {
        REG_CUTOFF   = 1'b0,
        REG_MAX_ITER = 1'b1
    } cfg_reg_t;

    // Microcode
    typedef logic [2:0] step_t;

    typedef enum logic [2:0] {
        OP_WAIT_IN = 3'd0,
        OP_MUL     = 3'd1,
        OP_ZUPD    = 3'd2,
        OP_TEST    = 3'd3,
        OP_EMIT    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MUL_CROSS = 2'd0,
        MUL_RE    = 2'd1,
        MUL_IM    = 2'd2
    } mul_sel_t;

    typedef struct packed {
        op_t      op;
        mul_sel_t sel;
        step_t    target;
    } ucode_t;

    localparam step_t STEP_WAIT  = 3'd0;
    localparam step_t STEP_CROSS = 3'd1;
    localparam step_t STEP_ZUPD  = 3'd2;
    localparam step_t STEP_SQ_RE = 3'd3;
    localparam step_t STEP_SQ_IM = 3'd4;
    localparam step_t STEP_TEST  = 3'd5;
    localparam step_t STEP_EMIT  = 3'd6;

    // Sequencer to datapath
    typedef struct packed {
        logic     load;
        logic     mul_start;
        logic     mul_capture;
        mul_sel_t mul_sel;
        logic     z_update;
        logic     emit;
    } dp_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic mul_done;
        logic stop;
        logic out_busy;
    } dp_stat_t;

    function automatic ucode_t ucode_rom(input step_t addr);
        ucode_t uc;
        case (addr)
            STEP_WAIT:  uc = '{op: OP_WAIT_IN, sel: MUL_CROSS, target: STEP_CROSS};
            STEP_CROSS: uc = '{op: OP_MUL,     sel: MUL_CROSS, target: STEP_ZUPD};
            STEP_ZUPD:  uc = '{op: OP_ZUPD,    sel: MUL_CROSS, target: STEP_SQ_RE};
            STEP_SQ_RE: uc = '{op: OP_MUL,     sel: MUL_RE,    target: STEP_SQ_IM};
            STEP_SQ_IM: uc = '{op: OP_MUL,     sel: MUL_IM,    target: STEP_TEST};
            // loop back to the cross product unless the point is finished
            STEP_TEST:  uc = '{op: OP_TEST,    sel: MUL_CROSS, target: STEP_CROSS};
            STEP_EMIT:  uc = '{op: OP_EMIT,    sel: MUL_CROSS, target: STEP_WAIT};
            default:    uc = '{op: OP_TEST,    sel: MUL_CROSS, target: STEP_WAIT};
        endcase
        return uc;
    endfunction

endpackage

// ===== rtl/mbe_mul.sv =====
`timescale 1ns / 1ps

module mbe_mul #(
    parameter int WIDTH = mbe_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [WIDTH-1:0]   op_a,
    input  logic [WIDTH-1:0]   op_b,
    output logic [2*WIDTH-1:0] product,
    output logic               done
);

    localparam int LIMB  = mbe_pkg::LIMB_W;
    localparam int LIMBS = (WIDTH + LIMB - 1) / LIMB;
    localparam int PW    = LIMBS * LIMB;
    localparam int IW    = (LIMBS > 1) ? $clog2(LIMBS) : 1;

    logic [PW-1:0]     a_reg, b_reg;
    logic [2*PW-1:0]   acc_reg, acc_next;
    logic [IW-1:0]     i_reg, j_reg;
    logic              busy_reg, done_reg;
    logic [LIMB-1:0]   a_limb, b_limb;
    logic [2*LIMB-1:0] pp;
    logic [2*PW-1:0]   pp_ext;
    logic              last;

    always_comb begin
        a_limb = a_reg[int'(i_reg) * LIMB +: LIMB];
        b_limb = b_reg[int'(j_reg) * LIMB +: LIMB];
        pp     = (2*LIMB)'(a_limb) * (2*LIMB)'(b_limb);
        pp_ext = '0;
        pp_ext[2*LIMB-1:0] = pp;
        acc_next = acc_reg + (pp_ext << ((int'(i_reg) + int'(j_reg)) * LIMB));
        last = (i_reg == IW'(LIMBS - 1)) && (j_reg == IW'(LIMBS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                j_reg    <= '0;
            end else if (busy_reg) begin
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else if (j_reg == IW'(LIMBS - 1)) begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= PW'(op_a);
            b_reg   <= PW'(op_b);
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign product = acc_reg[2*WIDTH-1:0];
    assign done    = done_reg;

endmodule

// ===== rtl/mbe_datapath.sv =====
`timescale 1ns / 1ps

module mbe_datapath #(
    parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH_DEFAULT,
    parameter int FRAC_BITS   = mbe_pkg::FRAC_BITS_DEFAULT,
    parameter int COUNT_WIDTH = mbe_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mbe_pkg::dp_ctrl_t           ctrl,
    output mbe_pkg::dp_stat_t           stat,
    input  logic signed [COORD_WIDTH-1:0] point_real,
    input  logic signed [COORD_WIDTH-1:0] point_imag,
    input  logic [mbe_pkg::CUTOFF_W-1:0]  cutoff,
    input  logic [COUNT_WIDTH-1:0]      max_iter,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [COUNT_WIDTH-1:0]      iteration_count
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W;
    localparam int XW = (PW > 64) ? PW : 64;
    localparam int SQ = mbe_pkg::SQ_W;
    localparam int SW = SQ + 2;   // signed sum of a 64-bit term and a coordinate
    localparam int TW = SQ + 3;   // threshold compare width

    logic [W-1:0]           c_re_reg, c_im_reg, z_re_reg, z_im_reg;
    logic [SQ-1:0]          xx_reg, yy_reg, cross_reg;
    logic                   cross_neg_reg, sat_reg;
    logic [COUNT_WIDTH-1:0] count_reg, out_count_reg;
    logic                   out_valid_reg;

    logic [W-1:0]           mag_re, mag_im, op_a, op_b;
    logic [PW-1:0]          product;
    logic                   mul_done;

    logic [XW-1:0]          p_ext, sh_cross, sh_sq;
    logic                   cross_ovf, sq_ovf;
    logic [SQ-1:0]          cross_val, sq_val;

    logic signed [SQ:0]     diff, cross_s;
    logic signed [SW-1:0]   sum_re, sum_im;
    logic                   fits_re, fits_im;
    logic [W-1:0]           new_re, new_im;

    logic [SQ:0]            mag_sq;
    logic [TW-1:0]          thr;
    logic [COUNT_WIDTH-1:0] limit;
    logic                   escape;

    assign mag_re = z_re_reg[W-1] ? (~z_re_reg + 1'b1) : z_re_reg;
    assign mag_im = z_im_reg[W-1] ? (~z_im_reg + 1'b1) : z_im_reg;

    always_comb begin
        case (ctrl.mul_sel)
            mbe_pkg::MUL_CROSS: begin
                op_a = mag_re;
                op_b = mag_im;
            end
            mbe_pkg::MUL_RE: begin
                op_a = mag_re;
                op_b = mag_re;
            end
            mbe_pkg::MUL_IM: begin
                op_a = mag_im;
                op_b = mag_im;
            end
            default: begin
                op_a = mag_re;
                op_b = mag_re;
            end
        endcase
    end

    mbe_mul #(
        .WIDTH (W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product),
        .done    (mul_done)
    );

    // Drop fraction bits and clamp at the square limit; the cross term folds in the factor 2
    always_comb begin
        p_ext     = XW'(product);
        sh_cross  = p_ext >> (FRAC_BITS - 1);
        sh_sq     = p_ext >> FRAC_BITS;
        cross_ovf = |sh_cross[XW-1:SQ];
        sq_ovf    = |sh_sq[XW-1:SQ];
        cross_val = cross_ovf ? {SQ{1'b1}} : sh_cross[SQ-1:0];
        sq_val    = sq_ovf ? {SQ{1'b1}} : sh_sq[SQ-1:0];
    end

    // Next z, clamped to the coordinate range
    always_comb begin
        diff    = $signed({1'b0, xx_reg}) - $signed({1'b0, yy_reg});
        cross_s = cross_neg_reg ? -$signed({1'b0, cross_reg}) : $signed({1'b0, cross_reg});
        sum_re  = SW'(diff) + SW'($signed(c_re_reg));
        sum_im  = SW'(cross_s) + SW'($signed(c_im_reg));
        fits_re = (&sum_re[SW-1:W-1]) | ~(|sum_re[SW-1:W-1]);
        fits_im = (&sum_im[SW-1:W-1]) | ~(|sum_im[SW-1:W-1]);
        if (fits_re) begin
            new_re = sum_re[W-1:0];
        end else begin
            new_re = sum_re[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        if (fits_im) begin
            new_im = sum_im[W-1:0];
        end else begin
            new_im = sum_im[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    // Escape test: |z|^2 strictly above cutoff, or any saturation in this iteration
    always_comb begin
        mag_sq = {1'b0, xx_reg} + {1'b0, yy_reg};
        thr    = TW'(cutoff) << FRAC_BITS;
        escape = sat_reg | (TW'(mag_sq) > thr);
        limit  = (max_iter == '0) ? COUNT_WIDTH'(1) : max_iter;
    end

    assign stat.mul_done = mul_done;
    assign stat.stop     = escape | (count_reg == limit);
    assign stat.out_busy = out_valid_reg & ~m_ready;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            c_re_reg  <= point_real;
            c_im_reg  <= point_imag;
            z_re_reg  <= '0;
            z_im_reg  <= '0;
            xx_reg    <= '0;
            yy_reg    <= '0;
            count_reg <= '0;
        end
        if (ctrl.mul_capture) begin
            case (ctrl.mul_sel)
                mbe_pkg::MUL_CROSS: begin
                    cross_reg     <= cross_val;
                    cross_neg_reg <= z_re_reg[W-1] ^ z_im_reg[W-1];
                    sat_reg       <= cross_ovf;
                end
                mbe_pkg::MUL_RE: begin
                    xx_reg  <= sq_val;
                    sat_reg <= sat_reg | sq_ovf;
                end
                mbe_pkg::MUL_IM: begin
                    yy_reg  <= sq_val;
                    sat_reg <= sat_reg | sq_ovf;
                end
                default: begin
                    sat_reg <= sat_reg;
                end
            endcase
        end
        if (ctrl.z_update) begin
            z_re_reg  <= new_re;
            z_im_reg  <= new_im;
            sat_reg   <= sat_reg | ~fits_re | ~fits_im;
            count_reg <= count_reg + 1'b1;
        end
        if (ctrl.emit) begin
            out_count_reg <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign iteration_count = out_count_reg;

endmodule

// ===== rtl/mbe_sequencer.sv =====
`timescale 1ns / 1ps

module mbe_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mbe_pkg::dp_stat_t stat,
    output mbe_pkg::dp_ctrl_t ctrl
);

    mbe_pkg::step_t  pc_reg, pc_next;
    logic            mul_wait_reg, mul_wait_next;
    mbe_pkg::ucode_t uc;

    assign uc      = mbe_pkg::ucode_rom(pc_reg);
    assign s_ready = (uc.op == mbe_pkg::OP_WAIT_IN);

    always_comb begin
        ctrl          = '0;
        pc_next       = pc_reg;
        mul_wait_next = mul_wait_reg;
        case (uc.op)
            mbe_pkg::OP_WAIT_IN: begin
                if (s_valid) begin
                    ctrl.load = 1'b1;
                    pc_next   = uc.target;
                end
            end
            mbe_pkg::OP_MUL: begin
                ctrl.mul_sel = uc.sel;
                if (!mul_wait_reg) begin
                    ctrl.mul_start = 1'b1;
                    mul_wait_next  = 1'b1;
                end else if (stat.mul_done) begin
                    ctrl.mul_capture = 1'b1;
                    mul_wait_next    = 1'b0;
                    pc_next          = uc.target;
                end
            end
            mbe_pkg::OP_ZUPD: begin
                ctrl.z_update = 1'b1;
                pc_next       = uc.target;
            end
            mbe_pkg::OP_TEST: begin
                // fall through to emit when done, otherwise take the loop jump
                pc_next = stat.stop ? pc_reg + 1'b1 : uc.target;
            end
            mbe_pkg::OP_EMIT: begin
                // hold while the previous result is still waiting
                if (!stat.out_busy) begin
                    ctrl.emit = 1'b1;
                    pc_next   = uc.target;
                end
            end
            default: begin
                pc_next = mbe_pkg::STEP_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= mbe_pkg::STEP_WAIT;
            mul_wait_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            mul_wait_reg <= mul_wait_next;
        end
    end

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps

// Escape-time iteration for one complex point c per input transaction.
// Input channel s_: s_point_real / s_point_imag, signed fixed point with
// FRAC_BITS fraction bits. Output channel m_: m_iteration_count, the number
// of z = z*z + c steps until |z|^2 first exceeds cutoff_squared (or any
// intermediate value saturates), capped at max_iterations (zero acts as one).
// Configuration: cfg_wr_en / cfg_index / cfg_wdata, index 0 cutoff_squared,
// index 1 max_iterations; write only while no point is in flight.
// Timing: one point at a time. Each iteration runs the cross product, the
// z update, the two squares and the escape test in that order; the three
// products share one 32x32 limb multiplier that works limb by limb with
// L = ceil(COORD_WIDTH/32) limbs per operand.
// The result sits in an output register, so the next point is accepted as
// soon as that result has been loaded; a stalled receiver holds the next
// result in the emit step until the output register frees.
// Reset (aresetn low, synchronous): sequencer returns to waiting for input,
// m_valid drops, registers return to cutoff 4 and limit 256.
module mandelbrot_escape_time #(
    parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH_DEFAULT,
    parameter int FRAC_BITS   = mbe_pkg::FRAC_BITS_DEFAULT,
    parameter int COUNT_WIDTH = mbe_pkg::COUNT_WIDTH_DEFAULT,
    localparam int CFG_W = (COUNT_WIDTH > mbe_pkg::CUTOFF_W) ? COUNT_WIDTH : mbe_pkg::CUTOFF_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_index,
    input  logic [CFG_W-1:0]              cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_point_real,
    input  logic signed [COORD_WIDTH-1:0] s_point_imag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [COUNT_WIDTH-1:0]        m_iteration_count
);

    logic [mbe_pkg::CUTOFF_W-1:0] cutoff_reg;
    logic [COUNT_WIDTH-1:0]       max_iter_reg;
    mbe_pkg::dp_ctrl_t            ctrl;
    mbe_pkg::dp_stat_t            stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg   <= mbe_pkg::CUTOFF_RESET;
            max_iter_reg <= COUNT_WIDTH'(mbe_pkg::MAX_ITER_RESET);
        end else if (cfg_wr_en) begin
            case (mbe_pkg::cfg_reg_t'(cfg_index))
                mbe_pkg::REG_CUTOFF:   cutoff_reg   <= cfg_wdata[mbe_pkg::CUTOFF_W-1:0];
                mbe_pkg::REG_MAX_ITER: max_iter_reg <= cfg_wdata[COUNT_WIDTH-1:0];
                default:               cutoff_reg   <= cutoff_reg;
            endcase
        end
    end

    mbe_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    mbe_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .stat            (stat),
        .point_real      (s_point_real),
        .point_imag      (s_point_imag),
        .cutoff          (cutoff_reg),
        .max_iter        (max_iter_reg),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .iteration_count (m_iteration_count)
    );

endmodule

// ===== rtl/mbe_checker.sv =====
`timescale 1ns / 1ps

module mbe_checker #(
    parameter int COUNT_WIDTH = mbe_pkg::COUNT_WIDTH_DEFAULT
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [COUNT_WIDTH-1:0] m_iteration_count
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_iteration_count))
        else $error("stalled result changed or dropped");

    // A point always takes at least one step
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_iteration_count != '0)
        else $error("zero iteration count");

    // One point at a time: busy right after an accepted input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a point is in flight");

    // A new result is loaded only from the emit step, never while waiting for input
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while waiting for input");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind mandelbrot_escape_time mbe_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_mbe_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_iteration_count (m_iteration_count)
);

// ===== tb/mandelbrot_escape_time_test.sv =====
`timescale 1ns / 1ps

module mandelbrot_escape_time_test;

    localparam int CW    = mbe_pkg::COORD_WIDTH_DEFAULT;
    localparam int FB    = mbe_pkg::FRAC_BITS_DEFAULT;
    localparam int NW    = mbe_pkg::COUNT_WIDTH_DEFAULT;
    localparam int CTW   = mbe_pkg::CUTOFF_W;
    localparam int CFG_W = (NW > CTW) ? NW : CTW;
    localparam int IDLE_PCT = 34;

    localparam logic [63:0]         SQ_CAP   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] COORD_HI = (128'sd1 <<< (CW - 1)) - 128'sd1;
    localparam logic signed [127:0] COORD_LO = -COORD_HI - 128'sd1;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [0:0]           cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [CW-1:0] s_point_real;
    logic signed [CW-1:0] s_point_imag;
    logic                 m_valid;
    logic                 m_ready;
    logic [NW-1:0]        m_iteration_count;

    logic [CTW-1:0]       cutoff_now;
    logic [NW-1:0]        limit_now;
    logic                 steady;
    logic [NW-1:0]        expected_counts[$];
    logic [NW-1:0]        want_count;
    int                   mismatch_count;

    mandelbrot_escape_time dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_point_real      (s_point_real),
        .s_point_imag      (s_point_imag),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // (a * b) >> shift on the full product, clamped to the square ceiling
    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                   input int shift, inout logic sat);
        logic [127:0] prod;
        prod = ({64'b0, a} * {64'b0, b}) >> shift;
        if (prod > {64'b0, SQ_CAP}) begin
            sat = 1'b1;
            return SQ_CAP;
        end
        return prod[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_coord(input logic signed [127:0] v,
                                                       inout logic sat);
        if (v > COORD_HI) begin
            sat = 1'b1;
            return COORD_HI[63:0];
        end
        if (v < COORD_LO) begin
            sat = 1'b1;
            return COORD_LO[63:0];
        end
        return v[63:0];
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic [NW-1:0] escape_steps(input logic signed [CW-1:0] c_re_in,
                                                   input logic signed [CW-1:0] c_im_in,
                                                   input logic [CTW-1:0] cut,
                                                   input logic [NW-1:0] lim);
        logic signed [63:0] c_re, c_im, zr, zi, cross_s;
        logic [63:0]        xx, yy, cross_term, sum, bound;
        logic               sat, neg;
        int unsigned        steps, cap;
        c_re  = 64'(c_re_in);
        c_im  = 64'(c_im_in);
        cap   = (lim == '0) ? 1 : 32'(lim);
        zr    = '0;
        zi    = '0;
        xx    = '0;
        yy    = '0;
        steps = 0;
        bound = 64'(cut) << FB;
        do begin
            sat = 1'b0;
            neg = (zr < 0) != (zi < 0);
            // doubling folds into a shift one bit shorter
            cross_term = scaled_product(magnitude(zr), magnitude(zi), FB - 1, sat);
            cross_s    = neg ? -$signed(cross_term) : $signed(cross_term);
            steps++;
            zr  = clamp_coord($signed({64'b0, xx}) - $signed({64'b0, yy}) + 128'(c_re), sat);
            zi  = clamp_coord(128'(cross_s) + 128'(c_im), sat);
            xx  = scaled_product(magnitude(zr), magnitude(zr), FB, sat);
            yy  = scaled_product(magnitude(zi), magnitude(zi), FB, sat);
            sum = xx + yy;
            if (sat || sum > bound)
                break;
        end while (steps < cap);
        return steps[NW-1:0];
    endfunction

    task automatic report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // check each result transaction against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                report_failure($sformatf("unexpected count %0d", m_iteration_count));
            end else begin
                want_count = expected_counts.pop_front();
                if (m_iteration_count !== want_count)
                    report_failure($sformatf("count expected %0d actual %0d",
                                             want_count, m_iteration_count));
            end
        end
    end

    always @(negedge aclk) begin
        m_ready = steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // entered and left just after a falling edge
    task automatic send_point(input logic signed [CW-1:0] re, input logic signed [CW-1:0] im);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
            @(negedge aclk);
        s_valid      = 1'b1;
        s_point_real = re;
        s_point_imag = im;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_counts.push_back(escape_steps(re, im, cutoff_now, limit_now));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain_results;
        s_valid = 1'b0;
        while (expected_counts.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input mbe_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] value);
        drain_results();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            mbe_pkg::REG_CUTOFF:   cutoff_now = value[CTW-1:0];
            mbe_pkg::REG_MAX_ITER: limit_now  = value[NW-1:0];
            default: ;
        endcase
    endtask

    // registers at their reset values; origin, cusp tips, cycles and coordinate extremes
    task automatic test_reset_defaults;
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'shE000_0000, 32'sh0000_0000);   // -2: lands exactly on the cutoff
        send_point(32'sh2000_0000, 32'sh0000_0000);   // +2: equal first, then out
        send_point(32'sh0400_0000, 32'sh0000_0000);
        send_point(32'shF000_0000, 32'sh0000_0000);
        send_point(32'sh0000_0000, 32'sh1000_0000);
        send_point(32'shF400_0000, 32'sh0199_9999);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh0000_0000);
        send_point(32'sh0000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    endtask

    // wide cutoff lets z grow past the coordinate range before it escapes
    task automatic test_saturation;
        write_reg(mbe_pkg::REG_CUTOFF, 16'd31);
        send_point(32'sh5800_0000, 32'sh0000_0000);
        send_point(32'sh0000_0000, 32'sh5800_0000);
        send_point(32'shA800_0000, 32'sh0000_0000);
        write_reg(mbe_pkg::REG_CUTOFF, 16'd16);
        send_point(32'sh3000_0000, 32'sh0000_0000);
    endtask

    task automatic test_zero_settings;
        write_reg(mbe_pkg::REG_CUTOFF, 16'd0);
        write_reg(mbe_pkg::REG_MAX_ITER, 16'd5);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh0000_0001, 32'sh0000_0000);   // square truncates to zero
        send_point(32'sh0000_4000, 32'sh0000_0000);
        send_point(32'sh0000_0000, 32'sh0000_4000);
        write_reg(mbe_pkg::REG_CUTOFF, 16'd4);
        write_reg(mbe_pkg::REG_MAX_ITER, 16'd0);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        write_reg(mbe_pkg::REG_MAX_ITER, 16'd1);
        send_point(32'shF000_0000, 32'sh0000_0000);
    endtask

    // full count range, but only points that escape in a bounded number of steps
    task automatic test_long_limit;
        logic [CW-1:0] mag_re;
        int            n;
        write_reg(mbe_pkg::REG_MAX_ITER, 16'hFFFF);
        send_point(32'shE000_0000, 32'sh0010_0000);
        send_point(32'sh0428_F5C2, 32'sh0000_0000);
        send_point(32'sh0414_7AE1, 32'sh0000_0000);
        for (n = 0; n < 8; n++) begin
            mag_re = $urandom_range(32'h2800_0000, 32'h7FFF_FFFF);
            send_point($urandom_range(0, 1) ? -$signed(mag_re) : $signed(mag_re), $urandom);
        end
    endtask

    task automatic test_random_regions;
        int                   phase, n, roll;
        logic [CFG_W-1:0]     word;
        logic signed [CW-1:0] re, im;
        for (phase = 0; phase < 10; phase++) begin
            word = CFG_W'($urandom);
            if ($urandom_range(0, 4) == 0)
                word[CTW-1:0] = CTW'(4);
            write_reg(mbe_pkg::REG_CUTOFF, word);
            roll = $urandom_range(0, 9);
            if (roll == 0)
                word = CFG_W'($urandom_range(0, 2));
            else if (roll < 7)
                word = CFG_W'($urandom_range(3, 48));
            else
                word = CFG_W'($urandom_range(49, 300));
            write_reg(mbe_pkg::REG_MAX_ITER, word);
            steady = (phase == 4);
            for (n = 0; n < 50; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    // around the set: re in [-2.5, 1.5], im in [-1.5, 1.5]
                    re = $urandom_range(0, 32'h4000_0000) - 32'h2800_0000;
                    im = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
                end else if (roll < 85) begin
                    re = $signed($urandom) >>> $urandom_range(0, 31);
                    im = $signed($urandom) >>> $urandom_range(0, 31);
                end else begin
                    re = $urandom;
                    im = $urandom;
                end
                send_point(re, im);
                // hold the sender until the block has emptied
                if (phase == 2 && n == 25)
                    drain_results();
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = mbe_pkg::REG_CUTOFF;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_point_real   = '0;
        s_point_imag   = '0;
        m_ready        = 1'b0;
        steady         = 1'b0;
        cutoff_now     = mbe_pkg::CUTOFF_RESET;
        limit_now      = NW'(mbe_pkg::MAX_ITER_RESET);
        mismatch_count = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_saturation();
        test_zero_settings();
        test_long_limit();
        test_random_regions();

        drain_results();
        repeat (40) @(negedge aclk);
        if (mismatch_count == 0 && expected_counts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #500_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
